/* rtl/ppid_pkg.sv */
`timescale 1ns / 1ps
package ppid_pkg;

  // Field and datapath widths
  localparam int KW        = 32;             // Q16.16 gains
  localparam int GAIN_FRAC = 16;             // fraction bits of a gain
  localparam int PW        = 24;             // Q.8 pressure, setpoint, drive
  localparam int DTW       = 16;             // elapsed milliseconds
  localparam int LW        = 23;             // unsigned limits
  localparam int EW        = 25;             // error
  localparam int DFW       = 26;             // error difference
  localparam int IW        = 56;             // error integral
  localparam int ACC_W     = 56;             // term accumulator
  localparam int MUL_W     = 32;             // multiplier operand
  localparam int PROD_W    = 2 * MUL_W;      // multiplier product
  localparam int INC_W     = EW + DTW;       // |error| * elapsed_ms
  localparam int DM_W      = KW - 1 + DFW;   // |kd| * |difference|
  localparam int SCL_W     = DM_W + 10;      // times 1000
  localparam int WIDE_W    = 88;             // |ki| * |integral|
  localparam int TERM_W    = 53;             // saturated term magnitude

  // Shared divider: radix 16, DIV_BITS quotient bits per cycle
  localparam int DIV_W     = WIDE_W - GAIN_FRAC;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PMIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PMAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FMAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BAND  = 3'd7;

  localparam logic [PW-1:0] PMIN_RST = 24'h80_0000;
  localparam logic [PW-1:0] PMAX_RST = 24'h7F_FFFF;
  localparam logic [LW-1:0] FMAX_RST = 23'h7F_FFFF;
  localparam logic [LW-1:0] OFFD_RST = 23'd20480;   // 80.0
  localparam logic [LW-1:0] BAND_RST = 23'd5120;    // 20.0

  // Arithmetic constants
  localparam logic [DTW-1:0]    DIV_K      = 16'd1000;
  localparam logic [IW-1:0]     INTEG_HOLD = 56'd102400;   // 400.0
  localparam logic [EW-1:0]     ZERO_BAND  = 25'd128;      // 0.5
  localparam logic [TERM_W-1:0] TERM_LIM   = {1'b1, {(TERM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [PW-1:0]  pressure;
    logic signed [PW-1:0]  setpoint;
    logic        [DTW-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [PW-1:0] drive;
    logic                 out_of_range;
  } out_item_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_EVAL,
    OP_MUL_INC,
    OP_INTEG,
    OP_MUL_P,
    OP_ADD_P,
    OP_MUL_ILO,
    OP_MUL_IHI,
    OP_I_SUM,
    OP_DIV_I,
    OP_ADD_I,
    OP_MUL_D,
    OP_SCALE_D,
    OP_DIV_D,
    OP_ADD_D,
    OP_OFFSET,
    OP_CLAMP,
    OP_WRITE
  } dp_op_t;

  typedef struct packed {
    logic in_range;
    logic dt_zero;
    logic div_done;
  } dp_status_t;

endpackage

/* rtl/ppid_ctrl.sv */
`timescale 1ns / 1ps
module ppid_ctrl import ppid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_op_t     op
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_EVAL,
    S_MUL_INC,
    S_INTEG,
    S_MUL_P,
    S_ADD_P,
    S_MUL_ILO,
    S_MUL_IHI,
    S_I_SUM,
    S_DIV_I,
    S_WAIT_I,
    S_ADD_I,
    S_MUL_D,
    S_SCALE_D,
    S_DIV_D,
    S_WAIT_D,
    S_ADD_D,
    S_OFFSET,
    S_CLAMP,
    S_WRITE
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        op         = OP_EVAL;
        state_next = status.in_range ? S_MUL_INC : S_WRITE;
      end
      S_MUL_INC: begin
        op         = OP_MUL_INC;
        state_next = S_INTEG;
      end
      S_INTEG: begin
        op         = OP_INTEG;
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        op         = OP_MUL_P;
        state_next = S_ADD_P;
      end
      S_ADD_P: begin
        op         = OP_ADD_P;
        state_next = S_MUL_ILO;
      end
      S_MUL_ILO: begin
        op         = OP_MUL_ILO;
        state_next = S_MUL_IHI;
      end
      S_MUL_IHI: begin
        op         = OP_MUL_IHI;
        state_next = S_I_SUM;
      end
      S_I_SUM: begin
        op         = OP_I_SUM;
        state_next = S_DIV_I;
      end
      S_DIV_I: begin
        op         = OP_DIV_I;
        state_next = S_WAIT_I;
      end
      S_WAIT_I: begin
        if (status.div_done) begin
          state_next = S_ADD_I;
        end
      end
      S_ADD_I: begin
        op         = OP_ADD_I;
        state_next = status.dt_zero ? S_OFFSET : S_MUL_D;
      end
      S_MUL_D: begin
        op         = OP_MUL_D;
        state_next = S_SCALE_D;
      end
      S_SCALE_D: begin
        op         = OP_SCALE_D;
        state_next = S_DIV_D;
      end
      S_DIV_D: begin
        op         = OP_DIV_D;
        state_next = S_WAIT_D;
      end
      S_WAIT_D: begin
        if (status.div_done) begin
          state_next = S_ADD_D;
        end
      end
      S_ADD_D: begin
        op         = OP_ADD_D;
        state_next = S_OFFSET;
      end
      S_OFFSET: begin
        op         = OP_OFFSET;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        op         = OP_CLAMP;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        // hold the finished result until the output register frees up
        if (slot_free) begin
          op         = OP_WRITE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_WRITE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Divider answer arrives a fixed time after its start
  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_I) |-> ##(DIV_STEPS + 1) status.div_done)
    else $error("divider result not ready when expected");

  // A pending result is never overwritten by the next one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && out_valid && !out_ready) |=> (state == S_WRITE))
    else $error("result written while output beat still pending");

endmodule

/* rtl/ppid_div.sv */
`timescale 1ns / 1ps
module ppid_div import ppid_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DTW-1:0]   divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DTW-1:0]       rem, rem_next, dvs;
  logic [DIV_W-1:0]     quo, quo_next;
  logic [DTW:0]         trial;

  // Restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial    = {rem_next, quo_next[DIV_W-1]};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next    = DTW'(trial - {1'b0, dvs});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[DTW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider restarted while busy");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && cnt == DIV_CNT_W'(DIV_STEPS - 1)) |=> (done && !busy))
    else $error("divider did not finish after its last step");

endmodule

/* rtl/ppid_dp.sv */
`timescale 1ns / 1ps
module ppid_dp import ppid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_op_t               op,
  output dp_status_t           status,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  output out_item_t            out_data
);

  // Configuration
  logic [KW-1:0] kp, ki, kd;
  logic [PW-1:0] pmin, pmax;
  logic [LW-1:0] fmax, offd, band;

  // Item and loop state
  logic [PW-1:0]     p_r, sp_r;
  logic [DTW-1:0]    dt_r;
  logic [EW-1:0]     err_mag, prev_err;
  logic              err_neg, err_pos, zero_band, integ_cond;
  logic [DFW-1:0]    diff_mag;
  logic              diff_neg;
  logic [IW-1:0]     integ;
  logic [PROD_W-1:0] mul_p;
  logic [WIDE_W-1:0] wide;
  logic [ACC_W-1:0]  acc;
  logic [PW-1:0]     fin_drive;
  logic              fin_oor;

  // Combinational values
  logic              in_range;
  logic [EW-1:0]     err_c, err_abs;
  logic [DFW-1:0]    diff_c, diff_abs;
  logic [IW-1:0]     integ_abs;
  logic [IW:0]       integ_sum, inc;
  logic [IW-1:0]     integ_sat;
  logic [KW-1:0]     kp_abs, ki_abs, kd_abs;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic [SCL_W-1:0]  m_ext, scaled;
  logic [DIV_W-1:0]  quotient;
  logic [TERM_W-1:0] term_mag;
  logic              div_start, div_done;
  logic [DTW-1:0]    divisor;
  logic [ACC_W-1:0]  off_ext, acc_off, fmax_ext, fmax_neg, clamp_val;

  function automatic logic [ACC_W-1:0] apply_sign(input logic [ACC_W-1:0] m,
                                                  input logic neg);
    return neg ? -m : m;
  endfunction

  assign in_range = !($signed(p_r) > $signed(pmax)) && !($signed(p_r) < $signed(pmin));

  assign err_c     = {sp_r[PW-1], sp_r} - {p_r[PW-1], p_r};
  assign err_abs   = err_c[EW-1] ? -err_c : err_c;
  assign diff_c    = {err_c[EW-1], err_c} - {prev_err[EW-1], prev_err};
  assign diff_abs  = diff_c[DFW-1] ? -diff_c : diff_c;
  assign integ_abs = integ[IW-1] ? -integ : integ;

  assign kp_abs = kp[KW-1] ? -kp : kp;
  assign ki_abs = ki[KW-1] ? -ki : ki;
  assign kd_abs = kd[KW-1] ? -kd : kd;

  // Saturating integral update
  assign inc       = (IW + 1)'(mul_p[INC_W-1:0]);
  assign integ_sum = err_neg ? {integ[IW-1], integ} - inc : {integ[IW-1], integ} + inc;
  always_comb begin
    if (integ_sum[IW] != integ_sum[IW-1]) begin
      integ_sat = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[IW-1:0];
    end
  end

  // Shared multiplier operands
  always_comb begin
    unique case (op) inside
      OP_MUL_INC: begin
        mul_a = MUL_W'(dt_r);
        mul_b = MUL_W'(err_mag);
      end
      OP_MUL_P: begin
        mul_a = kp_abs;
        mul_b = MUL_W'(err_mag);
      end
      OP_MUL_ILO: begin
        mul_a = ki_abs;
        mul_b = integ_abs[MUL_W-1:0];
      end
      OP_MUL_IHI: begin
        mul_a = ki_abs;
        mul_b = MUL_W'(integ_abs[IW-1:MUL_W]);
      end
      OP_MUL_D: begin
        mul_a = kd_abs;
        mul_b = MUL_W'(diff_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_prod = mul_a * mul_b;

  // times 1000 as 1024 - 32 + 8
  assign m_ext  = SCL_W'(mul_p[DM_W-1:0]);
  assign scaled = (m_ext << 10) - (m_ext << 5) + (m_ext << 3);

  assign div_start = (op == OP_DIV_I) || (op == OP_DIV_D);
  assign divisor   = (op == OP_DIV_D) ? dt_r : DIV_K;

  ppid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (wide[WIDE_W-1:GAIN_FRAC]),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  assign term_mag = (quotient > DIV_W'(TERM_LIM)) ? TERM_LIM : quotient[TERM_W-1:0];

  assign off_ext  = ACC_W'(offd);
  assign acc_off  = err_pos ? acc + off_ext : acc - off_ext;
  assign fmax_ext = ACC_W'(fmax);
  assign fmax_neg = -fmax_ext;
  always_comb begin
    if ($signed(acc) > $signed(fmax_ext)) begin
      clamp_val = fmax_ext;
    end else if ($signed(acc) < $signed(fmax_neg)) begin
      clamp_val = fmax_neg;
    end else begin
      clamp_val = acc;
    end
    if (zero_band) begin
      clamp_val = '0;
    end
  end

  assign status = '{in_range: in_range, dt_zero: (dt_r == '0), div_done: div_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      kp   <= '0;
      ki   <= '0;
      kd   <= '0;
      pmin <= PMIN_RST;
      pmax <= PMAX_RST;
      fmax <= FMAX_RST;
      offd <= OFFD_RST;
      band <= BAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP:   kp   <= cfg_data[KW-1:0];
        REG_KI:   ki   <= cfg_data[KW-1:0];
        REG_KD:   kd   <= cfg_data[KW-1:0];
        REG_PMIN: pmin <= cfg_data[PW-1:0];
        REG_PMAX: pmax <= cfg_data[PW-1:0];
        REG_FMAX: fmax <= cfg_data[LW-1:0];
        REG_OFFD: offd <= cfg_data[LW-1:0];
        REG_BAND: band <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // Loop state: clear when the sample falls outside the window
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      integ    <= '0;
    end else begin
      unique case (op) inside
        OP_EVAL: begin
          if (in_range) begin
            prev_err <= err_c;
          end else begin
            prev_err <= '0;
            integ    <= '0;
          end
        end
        OP_INTEG: begin
          if (integ_cond) begin
            integ <= integ_sat;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op) inside
      OP_LOAD: begin
        p_r  <= in_data.pressure;
        sp_r <= in_data.setpoint;
        dt_r <= in_data.elapsed_ms;
      end
      OP_EVAL: begin
        err_mag    <= err_abs;
        err_neg    <= err_c[EW-1];
        err_pos    <= !err_c[EW-1] && (err_c != '0);
        zero_band  <= (err_abs < ZERO_BAND);
        integ_cond <= (err_abs < EW'(band)) || (integ_abs > INTEG_HOLD);
        diff_mag   <= diff_abs;
        diff_neg   <= diff_c[DFW-1];
        fin_drive  <= '0;
        fin_oor    <= !in_range;
      end
      OP_MUL_INC, OP_MUL_P, OP_MUL_ILO, OP_MUL_D: begin
        mul_p <= mul_prod;
      end
      OP_MUL_IHI: begin
        wide  <= WIDE_W'(mul_p);
        mul_p <= mul_prod;
      end
      OP_I_SUM: begin
        wide <= wide + {mul_p[WIDE_W-MUL_W-1:0], {MUL_W{1'b0}}};
      end
      OP_ADD_P: begin
        acc <= apply_sign(ACC_W'(mul_p[PROD_W-1:GAIN_FRAC]), kp[KW-1] ^ err_neg);
      end
      OP_ADD_I: begin
        acc <= acc + apply_sign(ACC_W'(term_mag), ki[KW-1] ^ integ[IW-1]);
      end
      OP_SCALE_D: begin
        wide <= WIDE_W'(scaled);
      end
      OP_ADD_D: begin
        acc <= acc + apply_sign(ACC_W'(term_mag), kd[KW-1] ^ diff_neg);
      end
      OP_OFFSET: begin
        acc <= acc_off;
      end
      OP_CLAMP: begin
        fin_drive <= clamp_val[PW-1:0];
      end
      OP_WRITE: begin
        out_data.drive        <= fin_drive;
        out_data.out_of_range <= fin_oor;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/pressure_pid_with_deadband_unit.sv */
`timescale 1ns / 1ps
// Pressure PID loop with conditional integration and a dead band.
//
// Channels: in_valid/in_ready carry one sample beat (pressure, setpoint,
// elapsed_ms); out_valid/out_ready carry one result beat (drive,
// out_of_range) per sample. cfg_valid/cfg_ready write the eight loop
// registers by index; cfg_ready is always high. Write configuration only
// while no sample is in flight.
//
// Timing: one sample at a time. A sample outside the pressure window goes
// from the evaluate step straight to the output write. An in-range sample
// walks the shared 32x32 multiplier steps and the radix-16 divider passes:
// integral term / 1000, then derivative term / elapsed_ms, skipped when
// elapsed_ms is zero. The next sample is accepted the cycle after the
// result is written.
// Reset: gains zero, window fully open, limits and offset at their
// defaults, previous error and integral cleared. A stalled receiver holds
// the result beat; a finished next result waits until the beat leaves.
module pressure_pid_with_deadband_unit import ppid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  dp_op_t     op;
  dp_status_t status;

  // Registers are plain flops: take every write immediately
  assign cfg_ready = 1'b1;

  // Sequencer: walks the P, I and D steps and owns both handshakes
  ppid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  // Arithmetic, loop state, configuration and the output register
  ppid_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import ppid_pkg::*;

  // Run shape
  localparam int PHASES          = 24;    // random configuration phases
  localparam int ITEMS_PER_PHASE = 80;
  localparam int SETTLE_CYCLES   = 4;     // quiet cycles before a register write
  localparam int TAIL_CYCLES     = 64;    // longer than one in-range sample
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any beat
  localparam int MAX_REPORTS     = 40;

  // Loop arithmetic limits
  localparam longint TERM_CAP  = longint'(1) <<< 52;
  localparam longint INTEG_TOP = (longint'(1) <<< 55) - 1;
  localparam longint INTEG_BOT = -(longint'(1) <<< 55);
  localparam longint HOLD_LIM  = 102400;  // 400.0 in Q.8
  localparam longint DEAD_BAND = 128;     // 0.5 in Q.8
  localparam longint P_LO      = -(longint'(1) <<< 23);
  localparam longint P_HI      = (longint'(1) <<< 23) - 1;

  typedef enum logic [1:0] {ROW_CFG, ROW_FIXED, ROW_PRED} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DW-1:0]     val;
    in_item_t              smp;
    out_item_t             want;
  } step_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0]    cfg_data;

  pressure_pid_with_deadband_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Loop registers as the block should hold them, at their reset values
  longint kp_q      = 0;
  longint ki_q      = 0;
  longint kd_q      = 0;
  longint win_lo    = P_LO;
  longint win_hi    = P_HI;
  longint drive_lim = 8388607;
  longint offs_q    = 20480;
  longint band_q    = 5120;

  // Loop state: last error and the running error integral
  longint loop_prev_err = 0;
  longint loop_integral = 0;

  // Commands still owed by the block, oldest first
  out_item_t pending_cmds[$];

  step_row_t plan[$];

  int          err_count  = 0;
  int          sent       = 0;
  int          directed   = 0;
  int          checked    = 0;
  int          oor_seen   = 0;
  int          cfg_writes = 0;
  int          idle_cycles;
  int unsigned stall_left;
  int unsigned stall_draw;
  bit          steady     = 1'b0;   // phase with no gaps and no stalls

  // 100 MHz clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [87:0] mag_w(longint v);
    mag_w = (v < 0) ? -v : v;
  endfunction

  // Saturate a term magnitude to 2^52 and give it its sign
  function automatic longint clip_term(logic [87:0] m, bit neg);
    longint v;
    v = (m > TERM_CAP) ? TERM_CAP : longint'(m[63:0]);
    clip_term = neg ? -v : v;
  endfunction

  // Mirror a register write; bits above the register width drop out
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] d);
    case (idx)
      REG_KP:   kp_q      = $signed(d);
      REG_KI:   ki_q      = $signed(d);
      REG_KD:   kd_q      = $signed(d);
      REG_PMIN: win_lo    = $signed(d[PW-1:0]);
      REG_PMAX: win_hi    = $signed(d[PW-1:0]);
      REG_FMAX: drive_lim = d[LW-1:0];
      REG_OFFD: offs_q    = d[LW-1:0];
      REG_BAND: band_q    = d[LW-1:0];
      default: ;
    endcase
  endfunction

  // Advance the loop by one sample and return the command it should produce
  function automatic out_item_t pid_update(in_item_t s);
    longint      p, sp, dt, e, nxt, acc, drv;
    logic [87:0] prod;
    logic [87:0] dt_w;
    out_item_t   r;
    p  = $signed(s.pressure);
    sp = $signed(s.setpoint);
    dt = s.elapsed_ms;
    r  = '0;
    // Outside the window: clear the loop and report it
    if (p > win_hi || p < win_lo) begin
      loop_prev_err    = 0;
      loop_integral    = 0;
      r.out_of_range   = 1'b1;
      return r;
    end
    e = sp - p;
    // Integrate inside the band, or once the integral is past +-400
    if ((e < band_q && e > -band_q) || loop_integral > HOLD_LIM ||
        loop_integral < -HOLD_LIM) begin
      nxt = loop_integral + e * dt;
      if (nxt > INTEG_TOP) nxt = INTEG_TOP;
      if (nxt < INTEG_BOT) nxt = INTEG_BOT;
      loop_integral = nxt;
    end
    prod = mag_w(kp_q) * mag_w(e);
    acc  = clip_term(prod >> 16, (kp_q < 0) != (e < 0));
    prod = mag_w(ki_q) * mag_w(loop_integral);
    acc += clip_term(prod / 88'd65536000, (ki_q < 0) != (loop_integral < 0));
    if (dt != 0) begin
      dt_w = dt;
      prod = mag_w(kd_q) * mag_w(e - loop_prev_err) * 88'd1000;
      acc += clip_term(prod / (dt_w << 16), (kd_q < 0) != ((e - loop_prev_err) < 0));
    end
    acc += (e > 0) ? offs_q : -offs_q;
    loop_prev_err = e;
    drv = acc;
    if (drv > drive_lim) drv = drive_lim;
    else if (drv < -drive_lim) drv = -drive_lim;
    if (e > -DEAD_BAND && e < DEAD_BAND) drv = 0;
    r.drive = drv[PW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    if (err_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_cmds.size() == 0) begin
      report_mismatch($sformatf("stray result drive=%0d oor=%0b",
                                $signed(got.drive), got.out_of_range));
      return;
    end
    want = pending_cmds.pop_front();
    checked++;
    if (got.drive !== want.drive)
      report_mismatch($sformatf("result %0d drive %0d, expected %0d", checked,
                                $signed(got.drive), $signed(want.drive)));
    if (got.out_of_range !== want.out_of_range)
      report_mismatch($sformatf("result %0d out_of_range %0b, expected %0b", checked,
                                got.out_of_range, want.out_of_range));
  endtask

  // Result side: take each beat, then hold ready low for a drawn stall
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      check_result(out_data);
      stall_draw = steady ? 0 : $urandom_range(0, 10);
      stall_left <= stall_draw;
      out_ready  <= (stall_draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d commands outstanding",
               idle_cycles, pending_cmds.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int draw_gap();
    draw_gap = steady ? 0 : $urandom_range(0, 10);
  endfunction

  // Keep the low w bits, fill the rest with noise the block must drop
  function automatic logic [CFG_DW-1:0] with_noise(logic [CFG_DW-1:0] v, int w);
    logic [CFG_DW-1:0] mask;
    mask       = (32'h1 << w) - 1;
    with_noise = ($urandom & ~mask) | (v & mask);
  endfunction

  function automatic step_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
    step_row_t r;
    r      = '{kind: ROW_CFG, default: '0};
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic step_row_t sample_row(row_kind_t k, longint p, longint sp, longint dt,
                                           longint drv, bit oor);
    step_row_t r;
    r                   = '{kind: k, default: '0};
    r.kind              = k;
    r.smp.pressure      = p[PW-1:0];
    r.smp.setpoint      = sp[PW-1:0];
    r.smp.elapsed_ms    = dt[DTW-1:0];
    r.want.drive        = drv[PW-1:0];
    r.want.out_of_range = oor;
    return r;
  endfunction

  // Drop the sample channel and wait until the block owes nothing
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold a register beat until taken; valid stays up for a following write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_writes++;
  endtask

  // Present one sample beat after a gap, record what it must produce.
  // Valid stays high on return: the caller either presents the next
  // sample or drops valid in the same step.
  task automatic send_sample(in_item_t s, bit fixed, out_item_t want, int gap);
    out_item_t model_out;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    model_out = pid_update(s);
    pending_cmds.push_back(fixed ? want : model_out);
    sent++;
    if (model_out.out_of_range) oor_seen++;
  endtask

  function automatic logic [CFG_DW-1:0] pick_gain();
    longint g;
    case ($urandom_range(0, 5))
      0:       pick_gain = 32'h0000_0000;
      1:       pick_gain = 32'h8000_0000;
      2:       pick_gain = 32'h7FFF_FFFF;
      5:       pick_gain = $urandom;
      default: begin
        // a few units either way, where the terms stay below the clamp
        g = $urandom_range(0, 16 * 65536);
        g = g - 8 * 65536;
        pick_gain = g[CFG_DW-1:0];
      end
    endcase
  endfunction

  // Load all eight registers for one phase; first two phases take the extremes
  task automatic program_phase(int ph);
    longint lo, hi, lim, ofs, bnd;
    case (ph == 0 ? 0 : ph == 1 ? 1 : $urandom_range(0, 4))
      0:       begin lo = P_LO; hi = P_HI; end
      1:       begin lo = 0; hi = 0; end
      2:       begin lo = $urandom_range(1, 5000); hi = -longint'($urandom_range(1, 5000)); end
      default: begin
        lo = -longint'($urandom_range(0, 4000000));
        hi = $urandom_range(0, 4000000);
      end
    endcase
    case (ph == 0 ? 0 : ph == 1 ? 1 : $urandom_range(0, 4))
      0:       begin lim = 8388607; ofs = 8388607; bnd = 8388607; end
      1:       begin lim = 0; ofs = 0; bnd = 0; end
      2:       begin
        lim = $urandom_range(1, 8388607);
        ofs = $urandom_range(0, 8388607);
        bnd = $urandom_range(0, 8388607);
      end
      default: begin
        lim = $urandom_range(1, 60000);
        ofs = $urandom_range(0, 30000);
        bnd = $urandom_range(0, 20000);
      end
    endcase
    quiesce();
    write_reg(REG_KP, ph == 0 ? 32'h7FFF_FFFF : ph == 1 ? 32'h8000_0000 : pick_gain());
    write_reg(REG_KI, ph == 0 ? 32'h7FFF_FFFF : ph == 1 ? 32'h8000_0000 : pick_gain());
    write_reg(REG_KD, ph == 0 ? 32'h7FFF_FFFF : ph == 1 ? 32'h8000_0000 : pick_gain());
    write_reg(REG_PMIN, with_noise(lo[CFG_DW-1:0], PW));
    write_reg(REG_PMAX, with_noise(hi[CFG_DW-1:0], PW));
    write_reg(REG_FMAX, with_noise(lim[CFG_DW-1:0], LW));
    write_reg(REG_OFFD, with_noise(ofs[CFG_DW-1:0], LW));
    write_reg(REG_BAND, with_noise(bnd[CFG_DW-1:0], LW));
  endtask

  // Mostly in-window samples near the setpoint, where the loop does real
  // work; the rest are raw noise, window escapes and field extremes.
  function automatic in_item_t make_sample();
    longint   p, sp, dt, d, m;
    in_item_t s;
    case ($urandom_range(0, 9))
      6, 7: begin
        p  = $signed(24'($urandom));
        sp = $signed(24'($urandom));
        dt = $urandom_range(0, 65535);
      end
      8: begin
        if (win_lo <= win_hi && win_hi < P_HI)
          p = win_hi + 1 + $urandom_range(0, 1000);
        else if (win_lo <= win_hi && win_lo > P_LO)
          p = win_lo - 1 - $urandom_range(0, 1000);
        else
          p = $signed(24'($urandom));
        if (p > P_HI) p = P_HI;
        if (p < P_LO) p = P_LO;
        sp = $signed(24'($urandom));
        dt = $urandom_range(0, 1000);
      end
      9: begin
        p  = $urandom_range(0, 1) ? P_HI : P_LO;
        case ($urandom_range(0, 2))
          0:       sp = P_HI;
          1:       sp = P_LO;
          default: sp = 0;
        endcase
        dt = $urandom_range(0, 1) ? 65535 : 0;
      end
      default: begin
        if (win_lo <= win_hi) p = win_lo + $urandom_range(0, win_hi - win_lo);
        else p = $signed(24'($urandom));
        case ($urandom_range(0, 2))
          0:       m = 300;                  // around the dead band
          1:       m = band_q + 50;          // around the integration band
          default: m = 200000;
        endcase
        d  = $urandom_range(0, 2 * m);
        sp = p + d - m;
        if (sp > P_HI) sp = P_HI;
        if (sp < P_LO) sp = P_LO;
        case ($urandom_range(0, 7))
          0:       dt = 0;
          1:       dt = 65535;
          default: dt = $urandom_range(1, 200);
        endcase
      end
    endcase
    s.pressure   = p[PW-1:0];
    s.setpoint   = sp[PW-1:0];
    s.elapsed_ms = dt[DTW-1:0];
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // Directed rows. With all gains zero the command is just the offset
    // (80.0 at reset) toward the error sign, so those rows carry it typed in.
    plan.push_back(sample_row(ROW_FIXED, 0, 0, 0, 0, 0));             // zero error
    plan.push_back(sample_row(ROW_FIXED, 0, 128, 1, 20480, 0));       // edge of dead band
    plan.push_back(sample_row(ROW_FIXED, 0, 127, 1, 0, 0));           // inside dead band
    plan.push_back(sample_row(ROW_FIXED, 0, -128, 1, -20480, 0));
    plan.push_back(sample_row(ROW_FIXED, P_LO, P_HI, 65535, 20480, 0));
    plan.push_back(sample_row(ROW_FIXED, P_HI, P_LO, 65535, -20480, 0));
    // Narrow window to +-1000; upper data bits are noise
    plan.push_back(cfg_row(REG_PMIN, 32'hA5FF_FC18));
    plan.push_back(cfg_row(REG_PMAX, 32'h5A00_03E8));
    plan.push_back(sample_row(ROW_FIXED, 1001, 0, 5, 0, 1));          // above window
    plan.push_back(sample_row(ROW_FIXED, -1001, 0, 5, 0, 1));         // below window
    plan.push_back(sample_row(ROW_FIXED, 1000, 0, 3, -20480, 0));     // on the edge
    // Real gains, no offset, widest integration band, open window
    plan.push_back(cfg_row(REG_KP, 32'h0001_0000));
    plan.push_back(cfg_row(REG_KI, 32'h0003_0000));
    plan.push_back(cfg_row(REG_KD, 32'hFFFF_8000));
    plan.push_back(cfg_row(REG_FMAX, 32'd40000));
    plan.push_back(cfg_row(REG_OFFD, 32'd0));
    plan.push_back(cfg_row(REG_BAND, 32'h007F_FFFF));
    plan.push_back(cfg_row(REG_PMIN, 32'h0080_0000));
    plan.push_back(cfg_row(REG_PMAX, 32'h007F_FFFF));
    plan.push_back(sample_row(ROW_PRED, 0, 500, 10, 0, 0));
    plan.push_back(sample_row(ROW_PRED, 0, 500, 0, 0, 0));            // no elapsed time
    plan.push_back(sample_row(ROW_PRED, P_LO, P_HI, 65535, 0, 0));    // drive clamps
    plan.push_back(sample_row(ROW_PRED, 0, -300, 7, 0, 0));
    plan.push_back(sample_row(ROW_PRED, 0, 100, 1, 0, 0));
    // Band closed: only an integral already past 400 keeps growing
    plan.push_back(cfg_row(REG_BAND, 32'd0));
    plan.push_back(sample_row(ROW_PRED, 0, 200, 50, 0, 0));
    // Zero drive limit forces every command to zero
    plan.push_back(cfg_row(REG_FMAX, 32'd0));
    plan.push_back(sample_row(ROW_FIXED, 0, 5000, 2, 0, 0));
    // Inverted window rejects everything
    plan.push_back(cfg_row(REG_PMIN, 32'd100));
    plan.push_back(cfg_row(REG_PMAX, 32'hFFFF_FF9C));
    plan.push_back(sample_row(ROW_FIXED, 0, 0, 1, 0, 1));
    plan.push_back(sample_row(ROW_FIXED, P_HI, 0, 1, 0, 1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table; register rows wait for an idle block first
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          if (i == 0 || plan[i-1].kind != ROW_CFG) quiesce();
          write_reg(plan[i].idx, plan[i].val);
        end
        default: begin
          send_sample(plan[i].smp, plan[i].kind == ROW_FIXED, plan[i].want, draw_gap());
        end
      endcase
    end
    directed = sent;

    // Random phases: new register set, then a run of samples
    for (int ph = 0; ph < PHASES; ph++) begin
      program_phase(ph);
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_sample(make_sample(), 1'b0, '0, draw_gap());
    end

    // Drain, then give a stray result time to show up
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    steady = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d samples (%0d directed) over %0d register sets, %0d writes",
             sent, directed, PHASES + 1, cfg_writes);
    $display("Run: %0d commands checked, %0d outside the window, %0d mismatches",
             checked, oor_seen, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ppid_pkg.sv
rtl/ppid_ctrl.sv
rtl/ppid_div.sv
rtl/ppid_dp.sv
rtl/pressure_pid_with_deadband_unit.sv
tb/testbench.sv
